@@ src/kbc_pkg.sv @@
`timescale 1ns / 1ps
// kbc_pkg: shared types, latencies, register codes and saturating Q.30 arithmetic
// for the D2Q9 entropic collision pipeline. No dependencies.
package kbc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC           = 30;
    localparam int LANES          = 9;

    // unit latencies in clock cycles
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = 65;
    localparam int ACC_LAT = 3;

    // configuration register indexes (paddr[4:3])
    localparam logic [1:0] REG_RELAX = 2'd0;
    localparam logic [1:0] REG_DIR   = 2'd1;
    localparam logic [1:0] REG_GUARD = 2'd2;

    localparam logic [31:0] RELAX_RESET = 32'h4000_0000;
    localparam logic [35:0] DIR_RESET   = 36'hF37C4D150;
    localparam logic [15:0] GUARD_RESET = 16'd1;

    typedef logic signed [63:0] fx_t;
    typedef fx_t [LANES-1:0]    fx9_t;
    typedef logic signed [1:0]  dir_t;

    localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t FX_ONE = 64'sh0000_0000_4000_0000;
    localparam fx_t FX_TWO = 64'sh0000_0000_8000_0000;
    localparam fx_t W_REST = 64'sd477218588;
    localparam fx_t W_AXIS = 64'sd119304647;
    localparam fx_t W_DIAG = 64'sd29826162;

    function automatic logic [63:0] fx_mag(fx_t x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // saturating add / sub, limits +-(2^63 - 1)
    function automatic fx_t fx_add(fx_t a, fx_t b);
        logic signed [64:0] s;
        fx_t r;
        s = 65'(a) + 65'(b);
        if (s > 65'(FX_MAX))
            r = FX_MAX;
        else if (s < -65'(FX_MAX))
            r = -FX_MAX;
        else
            r = s[63:0];
        return r;
    endfunction

    function automatic fx_t fx_sub(fx_t a, fx_t b);
        logic signed [64:0] s;
        fx_t r;
        s = 65'(a) - 65'(b);
        if (s > 65'(FX_MAX))
            r = FX_MAX;
        else if (s < -65'(FX_MAX))
            r = -FX_MAX;
        else
            r = s[63:0];
        return r;
    endfunction

    // x times a small integer, exact then saturated
    function automatic fx_t fx_small(fx_t x, logic signed [3:0] k);
        logic signed [67:0] p;
        fx_t r;
        p = 68'(x) * 68'(k);
        if (p > 68'(FX_MAX))
            r = FX_MAX;
        else if (p < -68'(FX_MAX))
            r = -FX_MAX;
        else
            r = p[63:0];
        return r;
    endfunction

    // x times k/2^sh, magnitude rounded half away from zero
    function automatic fx_t fx_cmul(fx_t x, logic [3:0] k, logic [1:0] sh);
        logic [67:0] m;
        logic [67:0] half;
        fx_t r;
        half = (sh == 2'd0) ? 68'd0 : (68'd1 << (sh - 2'd1));
        m = (68'(fx_mag(x)) * 68'(k) + half) >> sh;
        if (m > 68'(FX_MAX))
            r = FX_MAX;
        else
            r = signed'(m[63:0]);
        return x[63] ? -r : r;
    endfunction

    function automatic dir_t dir_x(logic [35:0] tbl, int q);
        return signed'(tbl[4*q +: 2]);
    endfunction

    function automatic dir_t dir_y(logic [35:0] tbl, int q);
        return signed'(tbl[4*q+2 +: 2]);
    endfunction

    function automatic fx_t lat_weight(dir_t ex, dir_t ey);
        fx_t w;
        if (ex == 2'sd0 && ey == 2'sd0)
            w = W_REST;
        else if (ex == 2'sd0 || ey == 2'sd0)
            w = W_AXIS;
        else
            w = W_DIAG;
        return w;
    endfunction

    // shear part of a second-order moment set for one direction
    function automatic fx_t shear_part(dir_t ex, dir_t ey, fx_t m20, fx_t m02, fx_t m11);
        fx_t t;
        if (ex == 2'sd0 && ey == 2'sd0)
            t = -fx_add(m20, m02);
        else if (ey == 2'sd0)
            t = fx_cmul(m20, 4'd1, 2'd1);
        else if (ex == 2'sd0)
            t = fx_cmul(m02, 4'd1, 2'd1);
        else begin
            t = fx_cmul(m11, 4'd1, 2'd2);
            if (ex[1] ^ ey[1])
                t = -t;
        end
        return t;
    endfunction

endpackage

@@ src/kbc_dly.sv @@
`timescale 1ns / 1ps
// kbc_dly: fixed-length payload delay line used to align operands between stages.
// Depends on nothing.
module kbc_dly #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift line, no reset on payload
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

@@ src/kbc_mul.sv @@
`timescale 1ns / 1ps
// kbc_mul: three-stage signed Q.30 multiplier, 32x32 partial products, rounded
// half away from zero and saturated. Depends on kbc_pkg.
module kbc_mul import kbc_pkg::*; (
    input  logic clk,
    input  fx_t  a,
    input  fx_t  b,
    output fx_t  p
);

    logic [63:0]  ma, mb;
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic         neg1_reg, neg2_reg;
    logic [127:0] prod_reg;
    logic [63:0]  pm;
    fx_t          p_reg;

    assign ma = fx_mag(a);
    assign mb = fx_mag(b);

    // stage 1: partial products of the magnitudes
    always_ff @(posedge clk)
    begin
        ll_reg   <= ma[31:0]  * mb[31:0];
        lh_reg   <= ma[31:0]  * mb[63:32];
        hl_reg   <= ma[63:32] * mb[31:0];
        hh_reg   <= ma[63:32] * mb[63:32];
        neg1_reg <= a[63] ^ b[63];
    end

    // stage 2: full product plus rounding half
    always_ff @(posedge clk)
    begin
        prod_reg <= (128'(hh_reg) << 64) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32)
                  + 128'(ll_reg) + (128'd1 << (FRAC - 1));
        neg2_reg <= neg1_reg;
    end

    // stage 3: drop fraction, saturate, apply sign
    always_comb
    begin
        if (|prod_reg[127:FRAC+64] || prod_reg[FRAC+63])
            pm = 64'(FX_MAX);
        else
            pm = prod_reg[FRAC+63:FRAC];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg2_reg ? -signed'(pm) : signed'(pm);
    end

    assign p = p_reg;

endmodule

@@ src/kbc_div.sv @@
`timescale 1ns / 1ps
// kbc_div: pipelined restoring divider for (a * 2^30) / b, one quotient bit per
// stage, truncating and saturating. Depends on kbc_pkg.
module kbc_div import kbc_pkg::*; (
    input  logic clk,
    input  fx_t  a,
    input  fx_t  b,
    output fx_t  q
);

    localparam int QBITS = 63;

    typedef struct packed {
        logic neg;
        logic dz;
        logic an;
        logic az;
        logic over;
    } div_flags_t;

    logic [63:0]      na, nb;
    logic [63:0]      n_reg   [QBITS];
    logic [63:0]      d_reg   [QBITS];
    logic [63:0]      rem_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    div_flags_t       fl_reg  [QBITS+1];
    fx_t              q_out_reg;

    assign na = fx_mag(a);
    assign nb = fx_mag(b);

    // entry stage: magnitudes, flags, overflow test n >= d * 2^33
    always_ff @(posedge clk)
    begin
        n_reg[0]       <= na;
        d_reg[0]       <= nb;
        rem_reg[0]     <= na >> 33;
        q_reg[0]       <= '0;
        fl_reg[0].neg  <= a[63] ^ b[63];
        fl_reg[0].dz   <= (b == '0);
        fl_reg[0].an   <= a[63];
        fl_reg[0].az   <= (a == '0);
        fl_reg[0].over <= ({33'b0, na} >= {nb, 33'b0});
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k <= QBITS; k++)
    begin : g_stage
        localparam int BI = QBITS - k;
        logic        nbit;
        logic [64:0] rem_t;
        logic        fits;

        if (BI >= FRAC)
        begin : g_bit
            assign nbit = n_reg[k-1][BI-FRAC];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign rem_t = {rem_reg[k-1], nbit};
        assign fits  = (rem_t >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            fl_reg[k] <= fl_reg[k-1];
            if (fits)
                q_reg[k] <= q_reg[k-1] | (QBITS'(1) << BI);
            else
                q_reg[k] <= q_reg[k-1];
        end

        if (k < QBITS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                n_reg[k] <= n_reg[k-1];
                d_reg[k] <= d_reg[k-1];
                if (fits)
                    rem_reg[k] <= 64'(rem_t - {1'b0, d_reg[k-1]});
                else
                    rem_reg[k] <= rem_t[63:0];
            end
        end
    end

    // exit stage: x/0 saturates by the sign of x (0/0 gives 0), overflow by sign
    always_ff @(posedge clk)
    begin
        priority if (fl_reg[QBITS].dz)
            q_out_reg <= fl_reg[QBITS].az ? '0 : (fl_reg[QBITS].an ? -FX_MAX : FX_MAX);
        else if (fl_reg[QBITS].over)
            q_out_reg <= fl_reg[QBITS].neg ? -FX_MAX : FX_MAX;
        else
            q_out_reg <= fl_reg[QBITS].neg ? -signed'({1'b0, q_reg[QBITS]})
                                           : signed'({1'b0, q_reg[QBITS]});
    end

    assign q = q_out_reg;

endmodule

@@ src/kbc_acc9.sv @@
`timescale 1ns / 1ps
// kbc_acc9: three-stage saturating accumulator over nine lane terms, strictly in
// lane order 0..8. Depends on kbc_pkg.
module kbc_acc9 import kbc_pkg::*; (
    input  logic clk,
    input  fx9_t terms,
    output fx_t  sum
);

    fx_t  acc1_reg, acc2_reg, acc3_reg;
    fx_t  t1_reg [3:8];
    fx_t  t2_reg [6:8];

    // lanes 0..2
    always_ff @(posedge clk)
    begin
        acc1_reg <= fx_add(fx_add(terms[0], terms[1]), terms[2]);
        for (int i = 3; i < LANES; i++)
        begin
            t1_reg[i] <= terms[i];
        end
    end

    // lanes 3..5
    always_ff @(posedge clk)
    begin
        acc2_reg <= fx_add(fx_add(fx_add(acc1_reg, t1_reg[3]), t1_reg[4]), t1_reg[5]);
        for (int i = 6; i < LANES; i++)
        begin
            t2_reg[i] <= t1_reg[i];
        end
    end

    // lanes 6..8
    always_ff @(posedge clk)
    begin
        acc3_reg <= fx_add(fx_add(fx_add(acc2_reg, t2_reg[6]), t2_reg[7]), t2_reg[8]);
    end

    assign sum = acc3_reg;

endmodule

@@ src/d2q9_entropic_collision_unit.sv @@
`timescale 1ns / 1ps
// d2q9_entropic_collision_unit: top level of the KBC entropic D2Q9 collision pipeline
// with its APB register block. Depends on kbc_pkg, kbc_dly, kbc_mul, kbc_div, kbc_acc9.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | start & !busy                  | dist_0..dist_8, is_fluid
//  result   | done (one-cycle strobe)        | post_0..post_8
//  config   | psel & penable & pwrite        | paddr, pwdata (prdata on reads)
//
// One item is taken every cycle; busy is always low, as every stage is pipelined.
// A fluid item's result appears with done; the path runs through three dividers in
// series (velocity, per-lane entropy terms, gamma ratio) and the multipliers between
// them. Non-fluid items give no strobe. The receiver cannot hold results off, so the
// pipeline never stalls.
// rst_n clears the valid chain and the registers; payload stages are not reset.
module d2q9_entropic_collision_unit import kbc_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] dist_0,
    input  logic signed [DATA_WIDTH-1:0] dist_1,
    input  logic signed [DATA_WIDTH-1:0] dist_2,
    input  logic signed [DATA_WIDTH-1:0] dist_3,
    input  logic signed [DATA_WIDTH-1:0] dist_4,
    input  logic signed [DATA_WIDTH-1:0] dist_5,
    input  logic signed [DATA_WIDTH-1:0] dist_6,
    input  logic signed [DATA_WIDTH-1:0] dist_7,
    input  logic signed [DATA_WIDTH-1:0] dist_8,
    input  logic                         is_fluid,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] post_0,
    output logic signed [DATA_WIDTH-1:0] post_1,
    output logic signed [DATA_WIDTH-1:0] post_2,
    output logic signed [DATA_WIDTH-1:0] post_3,
    output logic signed [DATA_WIDTH-1:0] post_4,
    output logic signed [DATA_WIDTH-1:0] post_5,
    output logic signed [DATA_WIDTH-1:0] post_6,
    output logic signed [DATA_WIDTH-1:0] post_7,
    output logic signed [DATA_WIDTH-1:0] post_8,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    // stage times, counted in register stages after the input register
    localparam int T_MOM = ACC_LAT;
    localparam int T_U   = T_MOM + DIV_LAT;
    localparam int T_EU  = T_U + 1;
    localparam int T_UU  = T_U + MUL_LAT + 1;
    localparam int T_T   = T_UU + 2;
    localparam int T_FEQ = T_T + MUL_LAT;
    localparam int T_EM  = T_FEQ + ACC_LAT;
    localparam int T_DH  = T_EM + 3;
    localparam int T_P   = T_DH + MUL_LAT;
    localparam int T_Q   = T_P + DIV_LAT;
    localparam int T_SUM = T_Q + ACC_LAT;
    localparam int T_DEN = T_SUM + 1;
    localparam int T_RAT = T_DEN + DIV_LAT;
    localparam int T_GP  = T_RAT + MUL_LAT;
    localparam int T_G   = T_GP + 1;
    localparam int T_GD  = T_G + MUL_LAT;
    localparam int T_BR  = T_GD + 1 + MUL_LAT;
    localparam int T_OUT = T_BR + 1;

    logic [31:0]             relax_rate_reg;
    logic [35:0]             direction_table_reg;
    logic [15:0]             guard_value_reg;
    logic                    cfg_wr;
    logic [T_OUT:0]          vld_reg;
    logic signed [DATA_WIDTH-1:0] din [LANES];
    dir_t                    ex [LANES];
    dir_t                    ey [LANES];

    fx9_t f_reg;
    fx9_t t00, t10, t01, t11, t20, t02;
    fx_t  m00, m10, m01, m11, m20, m02;
    fx_t  ux, uy, uxx, uyy, uu_reg;
    fx9_t eu_reg, eu_d, eu2, ta_reg, tb_reg, t_reg, wm, feq;
    fx_t  tc_reg, m00_w;
    fx9_t te11, te20, te02;
    fx_t  e11, e20, e02;
    logic [191:0] msec_d;
    fx_t  m20_e, m02_e, m11_e;
    fx9_t sm_reg, se_reg, ds_reg, f_em, feq_em, d1_reg, d1_ds_reg;
    fx9_t dh_reg, ds_dh_reg, pdsdh, pdhdh, feq_p, qsd, qhh;
    fx_t  dsdh, dhdh, den_reg, dsdh_reg, ratio, gp, gamma_reg;
    fx_t  beta_reg, gamma0, g2_reg;
    fx9_t dh_g, gdh, ds_gd, r_reg, br, f_br;
    logic signed [DATA_WIDTH-1:0] post_reg [LANES];

    // ---------------------------------------------------------------
    // register block
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg      <= RELAX_RESET;
            direction_table_reg <= DIR_RESET;
            guard_value_reg     <= GUARD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_RELAX: relax_rate_reg      <= pwdata[31:0];
                REG_DIR:   direction_table_reg <= pwdata[35:0];
                REG_GUARD: guard_value_reg     <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_RELAX: prdata = 64'(relax_rate_reg);
            REG_DIR:   prdata = 64'(direction_table_reg);
            REG_GUARD: prdata = 64'(guard_value_reg);
            default:   prdata = '0;
        endcase
    end

    // lane velocity components
    always_comb
    begin
        for (int q = 0; q < LANES; q++)
        begin
            ex[q] = dir_x(direction_table_reg, q);
            ey[q] = dir_y(direction_table_reg, q);
        end
    end

    // ---------------------------------------------------------------
    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[T_OUT-1:0], start & is_fluid};
    end

    assign done = vld_reg[T_OUT];

    // ---------------------------------------------------------------
    // input register, sign-extended to 64 bits
    assign din[0] = dist_0;
    assign din[1] = dist_1;
    assign din[2] = dist_2;
    assign din[3] = dist_3;
    assign din[4] = dist_4;
    assign din[5] = dist_5;
    assign din[6] = dist_6;
    assign din[7] = dist_7;
    assign din[8] = dist_8;

    always_ff @(posedge clk)
    begin
        for (int q = 0; q < LANES; q++)
        begin
            if (64'(din[q]) < -FX_MAX)
                f_reg[q] <= -FX_MAX;
            else
                f_reg[q] <= 64'(din[q]);
        end
    end

    // raw moments
    always_comb
    begin
        for (int q = 0; q < LANES; q++)
        begin
            t00[q] = f_reg[q];
            t10[q] = fx_small(f_reg[q], 4'(ex[q]));
            t01[q] = fx_small(f_reg[q], 4'(ey[q]));
            t11[q] = fx_small(f_reg[q], 4'(ex[q]) * 4'(ey[q]));
            t20[q] = fx_small(f_reg[q], 4'(ex[q]) * 4'(ex[q]));
            t02[q] = fx_small(f_reg[q], 4'(ey[q]) * 4'(ey[q]));
        end
    end

    kbc_acc9 u_acc_m00 (.clk(clk), .terms(t00), .sum(m00));
    kbc_acc9 u_acc_m10 (.clk(clk), .terms(t10), .sum(m10));
    kbc_acc9 u_acc_m01 (.clk(clk), .terms(t01), .sum(m01));
    kbc_acc9 u_acc_m11 (.clk(clk), .terms(t11), .sum(m11));
    kbc_acc9 u_acc_m20 (.clk(clk), .terms(t20), .sum(m20));
    kbc_acc9 u_acc_m02 (.clk(clk), .terms(t02), .sum(m02));

    // velocity
    kbc_div u_div_ux (.clk(clk), .a(m10), .b(m00), .q(ux));
    kbc_div u_div_uy (.clk(clk), .a(m01), .b(m00), .q(uy));

    kbc_mul u_mul_uxx (.clk(clk), .a(ux), .b(ux), .p(uxx));
    kbc_mul u_mul_uyy (.clk(clk), .a(uy), .b(uy), .p(uyy));

    always_ff @(posedge clk)
    begin
        uu_reg <= fx_add(uxx, uyy);
        for (int q = 0; q < LANES; q++)
        begin
            eu_reg[q] <= fx_add(fx_small(ux, 4'(ex[q])), fx_small(uy, 4'(ey[q])));
        end
    end

    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(MUL_LAT)) u_dly_eu
        (.clk(clk), .din(eu_reg), .dout(eu_d));
    kbc_dly #(.WIDTH(64), .DEPTH(T_T - MUL_LAT - T_MOM)) u_dly_m00
        (.clk(clk), .din(m00), .dout(m00_w));
    kbc_dly #(.WIDTH(192), .DEPTH(T_EM - T_MOM)) u_dly_msec
        (.clk(clk), .din({m20, m02, m11}), .dout(msec_d));

    assign m20_e = msec_d[191:128];
    assign m02_e = msec_d[127:64];
    assign m11_e = msec_d[63:0];

    // polynomial of the equilibrium, two stages
    always_ff @(posedge clk)
    begin
        tc_reg <= fx_cmul(uu_reg, 4'd3, 2'd1);
        for (int q = 0; q < LANES; q++)
        begin
            ta_reg[q] <= fx_add(FX_ONE, fx_cmul(eu_d[q], 4'd3, 2'd0));
            tb_reg[q] <= fx_cmul(eu2[q], 4'd9, 2'd1);
            t_reg[q]  <= fx_sub(fx_add(ta_reg[q], tb_reg[q]), tc_reg);
        end
    end

    // per-lane equilibrium and products
    for (genvar q = 0; q < LANES; q++)
    begin : g_lane
        kbc_mul u_mul_eu2 (.clk(clk), .a(eu_reg[q]), .b(eu_reg[q]), .p(eu2[q]));
        kbc_mul u_mul_wm  (.clk(clk), .a(lat_weight(ex[q], ey[q])), .b(m00_w), .p(wm[q]));
        kbc_mul u_mul_feq (.clk(clk), .a(wm[q]), .b(t_reg[q]), .p(feq[q]));
        kbc_mul u_mul_sdh (.clk(clk), .a(ds_dh_reg[q]), .b(dh_reg[q]), .p(pdsdh[q]));
        kbc_mul u_mul_hdh (.clk(clk), .a(dh_reg[q]), .b(dh_reg[q]), .p(pdhdh[q]));
        kbc_div u_div_sd  (.clk(clk), .a(pdsdh[q]), .b(feq_p[q]), .q(qsd[q]));
        kbc_div u_div_hh  (.clk(clk), .a(pdhdh[q]), .b(feq_p[q]), .q(qhh[q]));
        kbc_mul u_mul_gdh (.clk(clk), .a(gamma_reg), .b(dh_g[q]), .p(gdh[q]));
        kbc_mul u_mul_br  (.clk(clk), .a(beta_reg), .b(r_reg[q]), .p(br[q]));
    end

    // equilibrium moments
    always_comb
    begin
        for (int q = 0; q < LANES; q++)
        begin
            te11[q] = fx_small(feq[q], 4'(ex[q]) * 4'(ey[q]));
            te20[q] = fx_small(feq[q], 4'(ex[q]) * 4'(ex[q]));
            te02[q] = fx_small(feq[q], 4'(ey[q]) * 4'(ey[q]));
        end
    end

    kbc_acc9 u_acc_e11 (.clk(clk), .terms(te11), .sum(e11));
    kbc_acc9 u_acc_e20 (.clk(clk), .terms(te20), .sum(e20));
    kbc_acc9 u_acc_e02 (.clk(clk), .terms(te02), .sum(e02));

    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(T_EM)) u_dly_f
        (.clk(clk), .din(f_reg), .dout(f_em));
    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(ACC_LAT)) u_dly_feq
        (.clk(clk), .din(feq), .dout(feq_em));
    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(T_P - T_EM)) u_dly_feqp
        (.clk(clk), .din(feq_em), .dout(feq_p));

    // shear and higher-order deviations
    always_ff @(posedge clk)
    begin
        for (int q = 0; q < LANES; q++)
        begin
            sm_reg[q]    <= shear_part(ex[q], ey[q], m20_e, m02_e, m11_e);
            se_reg[q]    <= shear_part(ex[q], ey[q], e20, e02, e11);
            d1_reg[q]    <= fx_sub(f_em[q], feq_em[q]);
            ds_reg[q]    <= fx_sub(sm_reg[q], se_reg[q]);
            d1_ds_reg[q] <= d1_reg[q];
            dh_reg[q]    <= fx_sub(d1_ds_reg[q], ds_reg[q]);
            ds_dh_reg[q] <= ds_reg[q];
        end
    end

    // entropic sums
    kbc_acc9 u_acc_sdh (.clk(clk), .terms(qsd), .sum(dsdh));
    kbc_acc9 u_acc_hdh (.clk(clk), .terms(qhh), .sum(dhdh));

    always_ff @(posedge clk)
    begin
        den_reg  <= fx_add(dhdh, 64'(guard_value_reg));
        dsdh_reg <= dsdh;
    end

    kbc_div u_div_ratio (.clk(clk), .a(dsdh_reg), .b(den_reg), .q(ratio));

    // beta and 1/beta follow the register; settled long before an item needs them
    always_ff @(posedge clk)
    begin
        beta_reg <= 64'(relax_rate_reg >> 1);
        g2_reg   <= fx_sub(FX_TWO, gamma0);
    end

    kbc_div u_div_g0 (.clk(clk), .a(FX_ONE), .b(beta_reg), .q(gamma0));
    kbc_mul u_mul_gp (.clk(clk), .a(g2_reg), .b(ratio), .p(gp));

    always_ff @(posedge clk)
    begin
        gamma_reg <= fx_sub(gamma0, gp);
    end

    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(T_G - T_DH)) u_dly_dh
        (.clk(clk), .din(dh_reg), .dout(dh_g));
    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(T_GD - T_DH)) u_dly_ds
        (.clk(clk), .din(ds_dh_reg), .dout(ds_gd));
    kbc_dly #(.WIDTH(64 * LANES), .DEPTH(T_BR - T_EM)) u_dly_fbr
        (.clk(clk), .din(f_em), .dout(f_br));

    // relaxation and output saturation
    always_ff @(posedge clk)
    begin
        for (int q = 0; q < LANES; q++)
        begin
            r_reg[q] <= fx_add(fx_add(ds_gd[q], ds_gd[q]), gdh[q]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int q = 0; q < LANES; q++)
        begin
            fx_t v;
            v = fx_sub(f_br[q], br[q]);
            if (v[63:DATA_WIDTH-1] == '0 || v[63:DATA_WIDTH-1] == '1)
                post_reg[q] <= v[DATA_WIDTH-1:0];
            else if (v[63])
                post_reg[q] <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            else
                post_reg[q] <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign post_0 = post_reg[0];
    assign post_1 = post_reg[1];
    assign post_2 = post_reg[2];
    assign post_3 = post_reg[3];
    assign post_4 = post_reg[4];
    assign post_5 = post_reg[5];
    assign post_6 = post_reg[6];
    assign post_7 = post_reg[7];
    assign post_8 = post_reg[8];

`ifndef SYNTH
    // a strobe always traces back to a fluid cell accepted one pipeline depth earlier
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && is_fluid, T_OUT + 1))
        else $error("result strobe without a matching fluid cell");

    // every fluid cell comes out
    a_fluid_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && is_fluid) |-> ##(T_OUT + 1) done)
        else $error("fluid cell lost in the pipeline");

    // a write to the relaxation register lands
    a_relax_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[4:3] == REG_RELAX) |=> (relax_rate_reg == $past(pwdata[31:0])))
        else $error("relaxation register write lost");
`endif

endmodule
